// ----- src/mi3_pkg.sv -----
// Package for the 3x3 matrix inverse unit: port payload types, default widths,
// cofactor product index tables and width helper functions.
// No dependencies.
`default_nettype none
package mi3_pkg;

  localparam int IO_W            = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int N_ENT           = 9;
  localparam int N_PROD          = 18;

  // One input beat: a row-major matrix of signed fixed-point entries.
  typedef struct packed {
    logic signed [IO_W-1:0] m00;
    logic signed [IO_W-1:0] m01;
    logic signed [IO_W-1:0] m02;
    logic signed [IO_W-1:0] m10;
    logic signed [IO_W-1:0] m11;
    logic signed [IO_W-1:0] m12;
    logic signed [IO_W-1:0] m20;
    logic signed [IO_W-1:0] m21;
    logic signed [IO_W-1:0] m22;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic signed [IO_W-1:0] inv00;
    logic signed [IO_W-1:0] inv01;
    logic signed [IO_W-1:0] inv02;
    logic signed [IO_W-1:0] inv10;
    logic signed [IO_W-1:0] inv11;
    logic signed [IO_W-1:0] inv12;
    logic signed [IO_W-1:0] inv20;
    logic signed [IO_W-1:0] inv21;
    logic signed [IO_W-1:0] inv22;
    logic signed [IO_W-1:0] det_value;
    logic                   singular;
    logic                   saturated;
  } out_t;

  // Cofactor k is PROD[2k] - PROD[2k+1]; each product is A[p] * B[p].
  localparam int PROD_A [N_PROD] = '{4, 5, 2, 1, 1, 2, 6, 3, 0, 6, 3, 0, 3, 6, 6, 0, 0, 3};
  localparam int PROD_B [N_PROD] = '{8, 7, 7, 8, 5, 4, 5, 8, 8, 2, 2, 5, 7, 4, 1, 7, 4, 1};

  // Cofactor width: exact, but wrapping at 64 bits for the widest entries.
  function automatic int cof_width(input int ew);
    return (2 * ew + 1 > 64) ? 64 : 2 * ew + 1;
  endfunction

  // Exact determinant width.
  function automatic int det_width(input int ew);
    return ew + cof_width(ew) + 2;
  endfunction

  // Width of one queue entry between front and back.
  function automatic int q_width(input int ew);
    return N_ENT * cof_width(ew) + det_width(ew) + N_ENT + 2;
  endfunction

endpackage
`default_nettype wire

// ----- src/matrix_inverse_3x3_unit.sv -----
// Top level of the 3x3 fixed-point matrix inverse unit.
// Uses mi3_pkg, mi3_front, mi3_queue and mi3_back (which holds mi3_div).
//
// The unit takes one matrix per clock cycle and never raises busy: the back
// end drains the queue one beat per cycle, so a new start is taken every
// cycle. Each result appears on out_data for exactly one cycle with out_valid
// high; the receiver must take it then. Each result passes through the
// six-stage cofactor and determinant pipeline, the queue, and the dividers,
// which resolve one quotient bit per stage. A matrix with a zero determinant
// gives singular high, all outputs zero and saturated low.
`default_nettype none
module matrix_inverse_3x3_unit import mi3_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);
  localparam int QW = q_width(ENTRY_WIDTH);

  logic          accept;
  logic          f_valid;
  logic [QW-1:0] f_data;
  logic          b_valid;
  logic [QW-1:0] b_data;

  // Nothing downstream holds the pipeline, so the input is always open.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  mi3_front #(
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_data  (in_data),
    .q_valid  (f_valid),
    .q_data   (f_data)
  );

  mi3_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .din        (f_data),
    .dout_valid (b_valid),
    .dout       (b_data)
  );

  mi3_back #(
    .FRAC_BITS   (FRAC_BITS),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (b_valid),
    .q_data    (b_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- src/mi3_queue.sv -----
// Short queue between the front and back ends of the matrix inverse unit.
// Depends on nothing; the entry width is a parameter.
`default_nettype none
module mi3_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              dout_valid,
  output logic [W-1:0]      dout
);
  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            pop;

  // The back end takes the head beat whenever one is present.
  assign dout_valid = (count_r != '0);
  assign pop        = dout_valid;
  assign dout       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CNTW'(1);
      2'b01:   count_nxt = count_r - CNTW'(1);
      default: count_nxt = count_r;
    endcase
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/mi3_front.sv -----
// Front end of the matrix inverse unit: cofactors, exact determinant and
// sign/magnitude classification, pipelined over six stages. Uses mi3_pkg.
`default_nettype none
module mi3_front import mi3_pkg::*; #(
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire in_t                             in_data,
  output logic                                 q_valid,
  output logic [q_width(ENTRY_WIDTH)-1:0]      q_data
);
  localparam int EW = ENTRY_WIDTH;
  localparam int CW = cof_width(EW);
  localparam int DW = det_width(EW);
  localparam int QW = q_width(EW);
  localparam int PW = 2 * EW;
  localparam int LW = CW / 2;
  localparam int HW = CW - LW;
  localparam int NSTG = 6;

  logic signed [IO_W-1:0] raw [N_ENT];
  logic signed [EW-1:0]   a_r [N_ENT];
  logic signed [PW-1:0]   prod_r [N_PROD];
  logic signed [EW-1:0]   a2_r [3];
  logic signed [CW-1:0]   adj_r [N_ENT], adj_nxt [N_ENT];
  logic signed [EW-1:0]   a3_r [3];
  logic signed [EW+HW-1:0] ph_r [3];
  logic signed [EW+LW:0]  pl_r [3];
  logic signed [CW-1:0]   adj4_r [N_ENT];
  logic signed [DW-1:0]   det_r, det_nxt;
  logic signed [CW-1:0]   adj5_r [N_ENT];
  logic [QW-1:0]          q_nxt;
  logic [NSTG-1:0]        v_r;

  assign raw[0] = in_data.m00;
  assign raw[1] = in_data.m01;
  assign raw[2] = in_data.m02;
  assign raw[3] = in_data.m10;
  assign raw[4] = in_data.m11;
  assign raw[5] = in_data.m12;
  assign raw[6] = in_data.m20;
  assign raw[7] = in_data.m21;
  assign raw[8] = in_data.m22;

  // Stage 1: take the low entry bits as two's complement.
  always_ff @(posedge clk) begin
    for (int k = 0; k < N_ENT; k++) begin
      a_r[k] <= $signed(raw[k][EW-1:0]);
    end
  end

  // Stage 2: the eighteen cofactor products.
  always_ff @(posedge clk) begin
    for (int p = 0; p < N_PROD; p++) begin
      prod_r[p] <= PW'(a_r[PROD_A[p]]) * PW'(a_r[PROD_B[p]]);
    end
    for (int t = 0; t < 3; t++) begin
      a2_r[t] <= a_r[t];
    end
  end

  // Stage 3: cofactor differences.
  always_comb begin
    for (int k = 0; k < N_ENT; k++) begin
      adj_nxt[k] = CW'((PW+1)'(prod_r[2*k]) - (PW+1)'(prod_r[2*k+1]));
    end
  end

  always_ff @(posedge clk) begin
    adj_r <= adj_nxt;
    a3_r  <= a2_r;
  end

  // Stage 4: determinant partial products, cofactor split in two halves.
  always_ff @(posedge clk) begin
    for (int t = 0; t < 3; t++) begin
      ph_r[t] <= (EW+HW)'(a3_r[t]) * (EW+HW)'($signed(adj_r[3*t][CW-1:LW]));
      pl_r[t] <= (EW+LW+1)'(a3_r[t]) * (EW+LW+1)'($signed({1'b0, adj_r[3*t][LW-1:0]}));
    end
    adj4_r <= adj_r;
  end

  // Stage 5: combine the partial products into the exact determinant.
  always_comb begin
    det_nxt = '0;
    for (int t = 0; t < 3; t++) begin
      det_nxt = det_nxt + (DW'(ph_r[t]) <<< LW) + DW'(pl_r[t]);
    end
  end

  always_ff @(posedge clk) begin
    det_r  <= det_nxt;
    adj5_r <= adj4_r;
  end

  // Stage 6: split into signs and magnitudes and pack the queue entry.
  always_comb begin
    logic          dneg;
    logic [DW-1:0] dmag;
    dneg = det_r[DW-1];
    dmag = dneg ? DW'(-det_r) : DW'(det_r);
    q_nxt = '0;
    for (int k = 0; k < N_ENT; k++) begin
      q_nxt[k*CW +: CW]         = adj5_r[k][CW-1] ? CW'(-adj5_r[k]) : CW'(adj5_r[k]);
      q_nxt[N_ENT*CW + DW + k]  = adj5_r[k][CW-1] ^ dneg;
    end
    q_nxt[N_ENT*CW +: DW]       = dmag;
    q_nxt[QW-2]                 = dneg;
    q_nxt[QW-1]                 = (det_r == '0);
  end

  always_ff @(posedge clk) begin
    q_data <= q_nxt;
  end

  // Beat valid through the six stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  assign q_valid = v_r[NSTG-1];

endmodule
`default_nettype wire

// ----- src/mi3_div.sv -----
// Pipelined restoring divider for one inverse entry: an overflow stage, then
// one quotient bit per stage. Uses mi3_pkg for width helpers.
`default_nettype none
module mi3_div import mi3_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic [cof_width(ENTRY_WIDTH)-1:0] num_mag,
  input  wire logic [det_width(ENTRY_WIDTH)-1:0] den,
  output logic [ENTRY_WIDTH-1:0]                 quo,
  output logic                                   ovf
);
  localparam int EW = ENTRY_WIDTH;
  localparam int CW = cof_width(EW);
  localparam int DW = det_width(EW);
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int RW = ((NW > DW + EW) ? NW : DW + EW) + 1;

  logic [RW-1:0] rem_r [EW+1];
  logic [DW-1:0] d_r   [EW+1];
  logic [EW-1:0] q_r   [EW+1];
  logic          ovf_r [EW+1];
  logic [RW-1:0] num_ext;

  assign num_ext = RW'(num_mag) << (2 * FRAC_BITS);

  // Entry stage: a quotient of more than ENTRY_WIDTH bits always clips.
  always_ff @(posedge clk) begin
    rem_r[0] <= num_ext;
    d_r[0]   <= den;
    q_r[0]   <= '0;
    ovf_r[0] <= (num_ext >= (RW'(den) << EW));
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s <= EW; s++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = RW'(d_r[s-1]) << (EW - s);
    assign ge    = (rem_r[s-1] >= trial);
    always_ff @(posedge clk) begin
      rem_r[s] <= ge ? rem_r[s-1] - trial : rem_r[s-1];
      d_r[s]   <= d_r[s-1];
      q_r[s]   <= {q_r[s-1][EW-2:0], ge};
      ovf_r[s] <= ovf_r[s-1];
    end
  end

  assign quo = q_r[EW];
  assign ovf = ovf_r[EW];

endmodule
`default_nettype wire

// ----- src/mi3_back.sv -----
// Back end of the matrix inverse unit: nine pipelined dividers, determinant
// scaling, saturation and the result register. Uses mi3_pkg and mi3_div.
`default_nettype none
module mi3_back import mi3_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  input  wire logic [q_width(ENTRY_WIDTH)-1:0] q_data,
  output logic                                 out_valid,
  output out_t                                 out_data
);
  localparam int EW = ENTRY_WIDTH;
  localparam int CW = cof_width(EW);
  localparam int DW = det_width(EW);
  localparam int QW = q_width(EW);

  logic [DW-1:0]      dmag, dshift, dlim;
  logic               dneg, sing;
  logic [N_ENT-1:0]   negs;
  logic [EW-1:0]      half;
  logic [EW-1:0]      det_sat;
  logic [EW-1:0]      quo [N_ENT];
  logic               ovf [N_ENT];

  logic               sv_r   [EW+1];
  logic               sing_r [EW+1];
  logic [N_ENT-1:0]   negs_r [EW+1];
  logic [EW-1:0]      detv_r [EW+1];

  logic [EW-1:0]      inv [N_ENT];
  logic [N_ENT-1:0]   clip;
  out_t               out_nxt;
  logic               out_valid_r;
  out_t               out_data_r;

  assign dmag = q_data[N_ENT*CW +: DW];
  assign negs = q_data[N_ENT*CW + DW +: N_ENT];
  assign dneg = q_data[QW-2];
  assign sing = q_data[QW-1];
  assign half = EW'(1) << (EW - 1);
  assign dlim = DW'(1) << (EW - 1);

  // Determinant output: drop the doubled fraction, then clip to range.
  assign dshift = dmag >> (2 * FRAC_BITS);
  always_comb begin
    if (!dneg) begin
      det_sat = (dshift > dlim - DW'(1)) ? half - EW'(1) : dshift[EW-1:0];
    end else begin
      det_sat = (dshift > dlim) ? half : EW'(-dshift[EW-1:0]);
    end
  end

  // The dividers, one per inverse entry.
  for (genvar k = 0; k < N_ENT; k++) begin : g_div
    mi3_div #(
      .FRAC_BITS   (FRAC_BITS),
      .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_div (
      .clk     (clk),
      .num_mag (q_data[k*CW +: CW]),
      .den     (dmag),
      .quo     (quo[k]),
      .ovf     (ovf[k])
    );
  end

  // Side data travels next to the dividers.
  always_ff @(posedge clk) begin
    sing_r[0] <= sing;
    negs_r[0] <= negs;
    detv_r[0] <= det_sat;
    for (int s = 1; s <= EW; s++) begin
      sing_r[s] <= sing_r[s-1];
      negs_r[s] <= negs_r[s-1];
      detv_r[s] <= detv_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= EW; s++) begin
        sv_r[s] <= 1'b0;
      end
    end else begin
      sv_r[0] <= q_valid;
      for (int s = 1; s <= EW; s++) begin
        sv_r[s] <= sv_r[s-1];
      end
    end
  end

  // Sign and saturation of each quotient.
  always_comb begin
    for (int k = 0; k < N_ENT; k++) begin
      if (ovf[k]) begin
        clip[k] = 1'b1;
        inv[k]  = negs_r[EW][k] ? half : half - EW'(1);
      end else if (!negs_r[EW][k]) begin
        clip[k] = quo[k][EW-1];
        inv[k]  = quo[k][EW-1] ? half - EW'(1) : quo[k];
      end else begin
        clip[k] = (quo[k] > half);
        inv[k]  = (quo[k] > half) ? half : EW'(-quo[k]);
      end
      if (sing_r[EW]) begin
        inv[k] = '0;
      end
    end
  end

  // Assemble the result beat.
  always_comb begin
    out_nxt.inv00     = IO_W'($signed(inv[0]));
    out_nxt.inv01     = IO_W'($signed(inv[1]));
    out_nxt.inv02     = IO_W'($signed(inv[2]));
    out_nxt.inv10     = IO_W'($signed(inv[3]));
    out_nxt.inv11     = IO_W'($signed(inv[4]));
    out_nxt.inv12     = IO_W'($signed(inv[5]));
    out_nxt.inv20     = IO_W'($signed(inv[6]));
    out_nxt.inv21     = IO_W'($signed(inv[7]));
    out_nxt.inv22     = IO_W'($signed(inv[8]));
    out_nxt.det_value = sing_r[EW] ? '0 : IO_W'($signed(detv_r[EW]));
    out_nxt.singular  = sing_r[EW];
    out_nxt.saturated = !sing_r[EW] && (clip != '0);
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sv_r[EW];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- tb/sv/mi3_checker.sv -----
// Result checker for the 3x3 matrix inverse unit: watches accepted matrices,
// computes the expected inverse and compares each result beat. Uses mi3_pkg.
module mi3_checker import mi3_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic busy,
  input  wire in_t  in_data,
  input  wire logic out_valid,
  input  wire out_t out_data,
  output int        fail_count,
  output int        pending_count,
  output int        result_count
);

  localparam int FB = FRAC_BITS_DEF;
  localparam int EW = ENTRY_WIDTH_DEF;

  out_t inverse_q[$];

  // Clip a magnitude with sign to the entry range; reports clipping.
  function automatic logic [31:0] clip_entry(input logic neg, input logic [127:0] mag,
                                             output logic clipped);
    logic [127:0] lim;
    lim = 128'd1 << (EW - 1);
    clipped = 1'b0;
    if (!neg) begin
      if (mag > lim - 1) begin
        clipped = 1'b1;
        return lim[31:0] - 32'd1;
      end
      return mag[31:0];
    end
    if (mag > lim) begin
      clipped = 1'b1;
      return lim[31:0];
    end
    return 32'd0 - mag[31:0];
  endfunction

  // Adjugate over determinant, exact in wide integers.
  function automatic out_t predict_inverse(input in_t m);
    logic signed [63:0] a [9];
    logic signed [63:0] adj [9];
    logic signed [127:0] det;
    logic [127:0] dmag, num, q, cmag;
    logic dneg, neg, c, any_clip;
    logic [31:0] r [10];
    out_t res;
    a[0] = m.m00; a[1] = m.m01; a[2] = m.m02;
    a[3] = m.m10; a[4] = m.m11; a[5] = m.m12;
    a[6] = m.m20; a[7] = m.m21; a[8] = m.m22;
    adj[0] = a[4] * a[8] - a[5] * a[7];
    adj[1] = a[2] * a[7] - a[1] * a[8];
    adj[2] = a[1] * a[5] - a[2] * a[4];
    adj[3] = a[6] * a[5] - a[3] * a[8];
    adj[4] = a[0] * a[8] - a[6] * a[2];
    adj[5] = a[3] * a[2] - a[0] * a[5];
    adj[6] = a[3] * a[7] - a[6] * a[4];
    adj[7] = a[6] * a[1] - a[0] * a[7];
    adj[8] = a[0] * a[4] - a[3] * a[1];
    det = 128'(a[0]) * 128'(adj[0]) + 128'(a[1]) * 128'(adj[3])
        + 128'(a[2]) * 128'(adj[6]);
    res = '0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    dneg = det[127];
    dmag = dneg ? -det : det;
    any_clip = 1'b0;
    for (int k = 0; k < 9; k++) begin
      cmag = adj[k][63] ? 128'(-adj[k]) : 128'(adj[k]);
      cmag = cmag & 128'hFFFF_FFFF_FFFF_FFFF;
      num = cmag << (2 * FB);
      q = num / dmag;
      neg = adj[k][63] != dneg;
      r[k] = clip_entry(neg, q, c);
      any_clip |= c;
    end
    r[9] = clip_entry(dneg, dmag >> (2 * FB), c);
    res = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], r[9], 1'b0, any_clip};
    return res;
  endfunction

  assign pending_count = inverse_q.size();

  // Predict on each accepted matrix beat, compare each result beat.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (start && !busy) inverse_q.push_back(predict_inverse(in_data));
      if (out_valid) begin
        result_count <= result_count + 1;
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = inverse_q.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the matrix inverse testbench: clock, reset, matrix stimulus and verdict.
// Uses mi3_pkg, matrix_inverse_3x3_unit and mi3_checker.
module testbench;
  import mi3_pkg::*;

  localparam int WATCHDOG = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;
  int   fail_count, pending_count, result_count;
  int   idle_pct = 0;
  int   quiet_cycles = 0;
  int   sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  matrix_inverse_3x3_unit dut (.clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data);
  mi3_checker chk (.clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
                   .fail_count, .pending_count, .result_count);

  // Watchdog: cycles with no beat accepted on either channel.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Entry values leaning on extremes, small values and exact integers.
  function automatic logic [31:0] pick_entry();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 3) << 16;
      3: return 32'(-($urandom_range(0, 5) << 16));
      4: return 32'(int'($urandom_range(0, 200000)) - 100000);
      5: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // Present one matrix beat, with random idle gaps, and wait for its acceptance.
  task automatic send_matrix(input in_t m);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_data <= m;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  function automatic in_t random_matrix();
    in_t m;
    m = {pick_entry(), pick_entry(), pick_entry(), pick_entry(), pick_entry(),
         pick_entry(), pick_entry(), pick_entry(), pick_entry()};
    // Well-conditioned sets: a scaled identity with random perturbation.
    if ($urandom_range(0, 2) == 0) begin
      m.m00 = $urandom_range(1, 8) << 16; m.m11 = $urandom_range(1, 8) << 16;
      m.m22 = 32'(-($urandom_range(1, 8) << 16));
    end
    // Singular sets: two equal rows.
    if ($urandom_range(0, 9) == 0) {m.m20, m.m21, m.m22} = {m.m00, m.m01, m.m02};
    return m;
  endfunction

  initial begin
    in_t m;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    // Directed: identity, zero, singular, tiny and huge determinants, extremes.
    send_matrix({32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000});
    send_matrix('0);
    send_matrix({9{32'h10000}});
    send_matrix({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1});
    send_matrix({9{32'h8000_0000}});
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix({32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0,
                 32'h0, 32'h0, 32'h8000_0000});
    send_matrix({32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0,
                 32'h0, 32'h0, 32'h7FFF_FFFF});
    send_matrix({32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                 32'h0, 32'h0, 32'h8000_0000});
    send_matrix({32'h20000, 32'h0, 32'h0, 32'h0, 32'hFFFE_0000, 32'h0, 32'h0, 32'h0, 32'h40000});
    send_matrix({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1,
                 32'h1, 32'h0, 32'hFFFF_FFFF});
    send_matrix({32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000});
    // Random phases: no idling, heavy idling, light idling, then no idling again.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 54 : (phase == 2) ? 19 : 0;
      for (int i = 0; i < 360; i++) send_matrix(random_matrix());
    end
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("tb: %0d matrices sent, %0d inverses checked, singular and clipped cases included",
             sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
